// ----- hdl/video_adc_pll_setting_calc_assert.svh -----
// Assertion macros for the video ADC PLL setting calculator.
// Needs i_clk and i_rst_n in the scope of the including module.
`ifndef VIDEO_ADC_PLL_SETTING_CALC_ASSERT_SVH
`define VIDEO_ADC_PLL_SETTING_CALC_ASSERT_SVH

// Antecedent implies consequent in the same cycle (consequent may carry ##n).
`define VAPLL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("vapll assertion failed");

// Antecedent implies consequent in the next cycle.
`define VAPLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("vapll assertion failed");

`endif

// ----- hdl/vapll_pkg.sv -----
// Types and constants for the video ADC PLL setting calculator.
// No dependencies.
`default_nettype none

package vapll_pkg;

    typedef struct packed {
        logic [11:0] pixels_per_line;
        logic [11:0] lines_per_frame;
        logic [7:0]  vertical_rate_hz;
        logic        interlaced;
    } t_timing_item;

    typedef struct packed {
        logic [1:0] vco_band;
        logic [2:0] pump_current_code;
    } t_pll_result;

    localparam int LR_W   = 20;   // line rate
    localparam int PIX_W  = 32;   // pixel rate
    localparam int LR2_W  = 40;   // line rate squared
    localparam int A_W    = 54;   // line rate^2 * pixels * postdiv
    localparam int HALF_W = 27;   // A split for the ratio multiply
    localparam int KQ_W   = 38;   // significant bits of the Q64 ratio
    localparam int PP_W   = HALF_W + KQ_W;
    localparam int SUM_W  = A_W + KQ_W + 1;
    localparam int H_W    = SUM_W - 64;
    localparam int THR_W  = 18;
    localparam int NUM_BINS_LIM = 7;

    localparam logic [PIX_W-1:0] LIM_LOW  = 32'd42000000;
    localparam logic [PIX_W-1:0] LIM_MID  = 32'd84000000;
    localparam logic [PIX_W-1:0] LIM_HIGH = 32'd140000000;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;
    localparam logic [1:0] BAND_TOP  = 2'd3;

    // floor((6.28/15.5)^2 / 12195122 * 2^64) = floor(49298 * 2^64 / 3662347575625)
    localparam logic [127:0] KQ_FULL = (128'd49298 << 64) / 128'd3662347575625;
    localparam logic [KQ_W-1:0] KQ = KQ_FULL[KQ_W-1:0];

    // Pump bin threshold times VCO gain (150, or 180 in the top band).
    function automatic logic [THR_W-1:0] pump_threshold(input logic [2:0] idx,
                                                        input logic gain_hi);
        logic [10:0] lim;
        logic [7:0]  gain;
        begin
            case (idx)
                3'd0:    lim = 11'd75;
                3'd1:    lim = 11'd125;
                3'd2:    lim = 11'd200;
                3'd3:    lim = 11'd300;
                3'd4:    lim = 11'd425;
                3'd5:    lim = 11'd625;
                default: lim = 11'd1125;
            endcase
            gain = gain_hi ? 8'd180 : 8'd150;
            return THR_W'(lim * gain);
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/video_adc_pll_setting_calc.sv -----
// Video ADC PLL setting calculator: six-stage pipeline from timing item to
// VCO band and charge pump bin. Uses vapll_pkg and the assertion macro header.
//
//  channel  | ports                       | transfer when
//  ---------+-----------------------------+------------------------
//  command  | start, busy, i_item         | start && !busy
//  result   | o_strobe, o_result          | o_strobe (one cycle)
//
// The result comes from the stage 6 output register while o_strobe is high;
// one item can be accepted on every edge while busy is low. The
// depth is set by the multiplier chain: line rate, then squared line rate and
// pixel rate, then times pixels, then the Q64 ratio product in two 27x38
// halves, then the recombining add, then the bin compares.
// busy is high only while reset is held; the result side cannot stall, so
// nothing backs up. Synchronous active-low reset clears the valid bits only.
`default_nettype none

`include "video_adc_pll_setting_calc_assert.svh"

module video_adc_pll_setting_calc (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  vapll_pkg::t_timing_item i_item,
    output logic                    o_strobe,
    output vapll_pkg::t_pll_result  o_result
);

    logic [5:0] r_vld;
    logic [5:0] n_vld;
    logic       w_accept;

    // stage 1: line rate
    logic [vapll_pkg::LR_W-1:0]  r1_lr,   n1_lr;
    logic [11:0]                 r1_htot;
    // stage 2: pixel rate and squared line rate
    logic [vapll_pkg::PIX_W-1:0] r2_pix,  n2_pix;
    logic [vapll_pkg::LR2_W-1:0] r2_lr2,  n2_lr2;
    logic [11:0]                 r2_htot;
    // stage 3: band select, postdiv-scaled estimate numerator
    logic [vapll_pkg::A_W-1:0]   r3_a,    n3_a;
    logic [1:0]                  r3_band, n3_band;
    logic [vapll_pkg::A_W-3:0]   w3_b;
    // stage 4: ratio partial products
    logic [vapll_pkg::PP_W-1:0]  r4_plo,  n4_plo;
    logic [vapll_pkg::PP_W-1:0]  r4_phi,  n4_phi;
    logic [1:0]                  r4_band;
    // stage 5: scaled estimate
    logic [vapll_pkg::SUM_W-1:0] w5_sum;
    logic [vapll_pkg::H_W-1:0]   r5_h,    n5_h;
    logic [1:0]                  r5_band;
    // stage 6: output register
    logic [2:0]                  n6_code;
    vapll_pkg::t_pll_result      r6_res;

    // hold off commands while reset is applied
    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;
    assign n_vld    = {r_vld[4:0], w_accept};

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: vrate * vtot, drop the low bit when interlaced
    always_comb begin
        n1_lr = vapll_pkg::LR_W'(i_item.vertical_rate_hz * i_item.lines_per_frame);
        if (i_item.interlaced) begin
            n1_lr = n1_lr >> 1;
        end
    end

    // stage 2: two independent multiplies
    always_comb begin
        n2_pix = vapll_pkg::PIX_W'(r1_lr * r1_htot);
        n2_lr2 = vapll_pkg::LR2_W'(r1_lr * r1_lr);
    end

    // stage 3: pick the band from the pixel rate; postdiv 4/2/1 is a shift
    always_comb begin
        w3_b = (vapll_pkg::A_W - 2)'(r2_lr2 * r2_htot);
        if (r2_pix < vapll_pkg::LIM_LOW) begin
            n3_band = vapll_pkg::BAND_LOW;
            n3_a    = {w3_b, 2'b00};
        end else if (r2_pix < vapll_pkg::LIM_MID) begin
            n3_band = vapll_pkg::BAND_MID;
            n3_a    = {1'b0, w3_b, 1'b0};
        end else if (r2_pix < vapll_pkg::LIM_HIGH) begin
            n3_band = vapll_pkg::BAND_HIGH;
            n3_a    = {2'b00, w3_b};
        end else begin
            n3_band = vapll_pkg::BAND_TOP;
            n3_a    = {2'b00, w3_b};
        end
    end

    // stage 4: A * KQ split into two halves of A
    always_comb begin
        n4_plo = vapll_pkg::PP_W'(r3_a[vapll_pkg::HALF_W-1:0] * vapll_pkg::KQ);
        n4_phi = vapll_pkg::PP_W'(r3_a[vapll_pkg::A_W-1:vapll_pkg::HALF_W]
                                  * vapll_pkg::KQ);
    end

    // stage 5: recombine and keep the bits above 2^64
    always_comb begin
        w5_sum = {1'b0, r4_phi, {vapll_pkg::HALF_W{1'b0}}}
               + {{(vapll_pkg::SUM_W - vapll_pkg::PP_W){1'b0}}, r4_plo};
        n5_h   = w5_sum[vapll_pkg::SUM_W-1:64];
    end

    // stage 6: thresholds rise, so the last one passed gives the bin
    always_comb begin
        n6_code = 3'd0;
        for (int i = 0; i < vapll_pkg::NUM_BINS_LIM; i++) begin
            if (r5_h >= vapll_pkg::H_W'(vapll_pkg::pump_threshold(3'(i),
                    r5_band == vapll_pkg::BAND_TOP))) begin
                n6_code = 3'(i + 1);
            end
        end
    end

    // payload registers: no reset, qualified by the valid bits
    always_ff @(posedge i_clk) begin
        r1_lr                   <= n1_lr;
        r1_htot                 <= i_item.pixels_per_line;
        r2_pix                  <= n2_pix;
        r2_lr2                  <= n2_lr2;
        r2_htot                 <= r1_htot;
        r3_a                    <= n3_a;
        r3_band                 <= n3_band;
        r4_plo                  <= n4_plo;
        r4_phi                  <= n4_phi;
        r4_band                 <= r3_band;
        r5_h                    <= n5_h;
        r5_band                 <= r4_band;
        r6_res.vco_band          <= r5_band;
        r6_res.pump_current_code <= n6_code;
    end

    assign o_strobe = r_vld[5];
    assign o_result = r6_res;

    // every transfer is followed by its result strobe
    `VAPLL_ASSERT_IMPL(a_latency, w_accept, ##6 o_strobe)
    // a zero estimate lands in the lowest pump bin
    `VAPLL_ASSERT_NEXT(a_zero_bin, r_vld[4] && (r5_h == '0),
        o_result.pump_current_code == 3'd0)
    // a pixel rate at or above the high limit always gives the top band
    `VAPLL_ASSERT_NEXT(a_top_band, r_vld[1] && (r2_pix >= vapll_pkg::LIM_HIGH),
        r3_band == vapll_pkg::BAND_TOP)

endmodule

`default_nettype wire

// ----- tb/sv/tb_video_adc_pll_setting_calc.sv -----
// Self-checking testbench for the video ADC PLL setting calculator.
// Drives timing items through the command port and checks VCO band and pump bin.
// Depends on vapll_pkg and the video_adc_pll_setting_calc RTL only.
`timescale 1ns / 1ps

module tb_video_adc_pll_setting_calc;

    // Pipeline depth of the DUT, in stages.
    localparam int LATENCY    = 6;
    // Cycles without any transfer before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;
    // Largest line rate the fields allow: 255 Hz * 4095 lines.
    localparam logic [63:0] MAX_LINE_RATE = 64'd1044225;
    localparam logic [63:0] GAIN_BASE = 64'd150;
    localparam logic [63:0] GAIN_TOP  = 64'd180;
    // Loop filter ratio with 64 fractional bits, truncated.
    localparam logic [127:0] RATIO_Q64 = (128'd49298 << 64) / 128'd3662347575625;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    vapll_pkg::t_timing_item i_item;
    logic                    o_strobe;
    vapll_pkg::t_pll_result  o_result;

    // Settings predicted for accepted items, oldest first.
    vapll_pkg::t_pll_result pending_settings[$];

    int unsigned n_sent;
    int unsigned n_directed;
    int unsigned n_checked;
    int unsigned n_mismatch;
    int unsigned idle_cycles;
    bit [3:0]    bands_seen;
    bit [7:0]    bins_seen;

    video_adc_pll_setting_calc dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Pump current bin limits, lowest first.
    function automatic logic [10:0] pump_limit(input int idx);
        case (idx)
            0:       return 11'd75;
            1:       return 11'd125;
            2:       return 11'd200;
            3:       return 11'd300;
            4:       return 11'd425;
            5:       return 11'd625;
            default: return 11'd1125;
        endcase
    endfunction

    // Scaled pump estimate: upper 64 bits of (lr^2 * pixels * postdiv) * ratio.
    function automatic logic [63:0] pump_estimate(input logic [63:0] line_rate,
                                                  input logic [63:0] htot,
                                                  input logic [63:0] postdiv);
        logic [127:0] prod;
        prod = 128'(line_rate * line_rate * htot * postdiv) * RATIO_Q64;
        return prod[127:64];
    endfunction

    function automatic vapll_pkg::t_pll_result predict_setting(
            input vapll_pkg::t_timing_item it);
        logic [63:0] line_rate;
        logic [63:0] pix_rate;
        logic [63:0] postdiv;
        logic [63:0] gain;
        logic [63:0] scaled;
        vapll_pkg::t_pll_result r;
        int          i;
        line_rate = 64'(it.vertical_rate_hz) * 64'(it.lines_per_frame);
        // Interlaced video halves the line rate and drops the low bit.
        if (it.interlaced) begin
            line_rate = line_rate >> 1;
        end
        pix_rate = line_rate * 64'(it.pixels_per_line);
        gain = (pix_rate < 64'(vapll_pkg::LIM_HIGH)) ? GAIN_BASE : GAIN_TOP;
        if (pix_rate < 64'(vapll_pkg::LIM_LOW)) begin
            r.vco_band = vapll_pkg::BAND_LOW;
            postdiv    = 64'd4;
        end else if (pix_rate < 64'(vapll_pkg::LIM_MID)) begin
            r.vco_band = vapll_pkg::BAND_MID;
            postdiv    = 64'd2;
        end else if (pix_rate < 64'(vapll_pkg::LIM_HIGH)) begin
            r.vco_band = vapll_pkg::BAND_HIGH;
            postdiv    = 64'd1;
        end else begin
            r.vco_band = vapll_pkg::BAND_TOP;
            postdiv    = 64'd1;
        end
        scaled = pump_estimate(line_rate, 64'(it.pixels_per_line), postdiv);
        // Compare cross-multiplied by the gain; equality lands in the upper bin.
        r.pump_current_code = 3'd0;
        for (i = 0; i < 7; i++) begin
            if (scaled >= 64'(pump_limit(i)) * gain) begin
                r.pump_current_code = 3'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic vapll_pkg::t_timing_item make_item(input int h, input int l,
                                                          input int v, input bit ilace);
        vapll_pkg::t_timing_item it;
        it.pixels_per_line  = 12'(h);
        it.lines_per_frame  = 12'(l);
        it.vertical_rate_hz = 8'(v);
        it.interlaced       = ilace;
        return it;
    endfunction

    // Mix of plausible video modes, raw noise, slow modes and items that sit
    // close to one of the band limits.
    function automatic vapll_pkg::t_timing_item random_item();
        vapll_pkg::t_timing_item it;
        int           pick;
        int           lim;
        int           h;
        int           lr_t;
        int           v;
        int           l;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it = make_item($urandom_range(300, 3000), $urandom_range(200, 1300),
                           $urandom_range(20, 130), 1'($urandom_range(0, 1)));
        end else if (pick < 65) begin
            it = 33'({$urandom, $urandom});
        end else if (pick < 85) begin
            it = make_item($urandom_range(0, 4095), $urandom_range(0, 600),
                           $urandom_range(0, 60), 1'($urandom_range(0, 1)));
        end else begin
            case ($urandom_range(0, 2))
                0:       lim = 42000000;
                1:       lim = 84000000;
                default: lim = 140000000;
            endcase
            h    = $urandom_range(1000, 4095);
            lr_t = lim / h + $urandom_range(0, 2) - 1;
            v    = $urandom_range(64, 255);
            l    = lr_t / v;
            if (l > 4095) begin
                l = 4095;
            end
            it = make_item(h, l, v, 1'b0);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Present one item and hold it until the transfer; call at a rising edge.
    task automatic send_item(input vapll_pkg::t_timing_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_settings.push_back(predict_setting(it));
        n_sent++;
    endtask

    // Drop start for a number of cycles and scramble the item bus meanwhile.
    task automatic hold_off(input int cycles);
        start  <= 1'b0;
        i_item <= 33'({$urandom, $urandom});
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 19));
        end
    endtask

    // Hold off new items until every predicted setting has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_settings.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero factors force band 0 and bin 0; full-scale fields exercise the widest
    // products in the pipeline.
    task automatic test_zero_and_extremes();
        send_item(make_item(0, 0, 0, 1'b0));
        send_item(make_item(0, 4095, 255, 1'b0));
        maybe_idle();
        send_item(make_item(4095, 0, 255, 1'b1));
        send_item(make_item(4095, 4095, 0, 1'b0));
        send_item(make_item(4095, 4095, 255, 1'b0));
        maybe_idle();
        send_item(make_item(4095, 4095, 255, 1'b1));
        send_item(make_item(1, 1, 1, 1'b0));
        // Line rate of one halves to zero.
        send_item(make_item(4095, 1, 1, 1'b1));
        n_directed += 8;
    endtask

    // Pixel rate exactly on each band limit and one pixel-per-line step below it.
    task automatic test_band_limits();
        send_item(make_item(2000, 350, 60, 1'b0));
        send_item(make_item(1999, 350, 60, 1'b0));
        send_item(make_item(2000, 700, 60, 1'b1));
        maybe_idle();
        send_item(make_item(2000, 700, 60, 1'b0));
        send_item(make_item(1999, 700, 60, 1'b0));
        send_item(make_item(2000, 700, 100, 1'b0));
        maybe_idle();
        send_item(make_item(1999, 700, 100, 1'b0));
        n_directed += 7;
    endtask

    // Odd line rates with interlace: the halving must truncate.
    task automatic test_odd_interlace();
        send_item(make_item(800, 525, 61, 1'b1));
        send_item(make_item(1, 1, 255, 1'b1));
        n_directed += 2;
    endtask

    // Search for items whose scaled estimate lands exactly on each pump bin
    // limit. Keep the pixel count tiny so the estimate rises by less than one
    // per line-rate step and every integer is hit; the band stays at 0, so
    // postdiv is 4 and the gain is the base gain.
    task automatic test_pump_thresholds();
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lr;
        logic [63:0] n;
        int          t;
        int          h;
        int          k;
        int          v;
        bit          found;
        for (t = 0; t < 7; t++) begin
            target = 64'(pump_limit(t)) * GAIN_BASE;
            found  = 1'b0;
            for (h = 1; h <= 8 && !found; h++) begin
                if (pump_estimate(MAX_LINE_RATE, 64'(h), 64'd4) < target) begin
                    continue;
                end
                lo = 64'd1;
                hi = MAX_LINE_RATE;
                while (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (pump_estimate(mid, 64'(h), 64'd4) >= target) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
                // Walk the run of line rates on the limit; factor each into
                // rate * lines, directly or through the interlace halving.
                for (lr = lo; lr <= MAX_LINE_RATE && !found
                        && pump_estimate(lr, 64'(h), 64'd4) == target; lr++) begin
                    for (k = 0; k < 3 && !found; k++) begin
                        n = (k == 0) ? lr : 2 * lr + 64'(k - 1);
                        for (v = 255; v >= 1 && !found; v--) begin
                            if (n % v == 0 && n / v <= 4095) begin
                                send_item(make_item(h, int'(n / v), v, k != 0));
                                n_directed++;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    endtask

    task automatic test_random_traffic(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_item(random_item());
            maybe_idle();
            if (i % 128 == 127) begin
                drain_results();
            end
        end
    endtask

    // Full-rate stream at the end: one transfer on every edge while busy is low.
    task automatic test_back_to_back(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_item(random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    // The strobe marks a one-cycle result; take it at the edge that ends it.
    always @(posedge i_clk) begin : check_results
        vapll_pkg::t_pll_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_settings.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("%0t: unexpected result band=%0d bin=%0d", $realtime,
                             o_result.vco_band, o_result.pump_current_code);
                end
            end else begin
                want = pending_settings.pop_front();
                n_checked++;
                bands_seen[want.vco_band]          = 1'b1;
                bins_seen[want.pump_current_code] = 1'b1;
                if (o_result.vco_band !== want.vco_band
                        || o_result.pump_current_code !== want.pump_current_code) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("%0t: mismatch on result %0d: %s %0d got %0d, %s %0d got %0d",
                                 $realtime, n_checked, "band exp", want.vco_band,
                                 o_result.vco_band, "bin exp", want.pump_current_code,
                                 o_result.pump_current_code);
                    end
                end
            end
        end
    end

    // End the run if neither side transfers for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $realtime,
                     pending_settings.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        n_sent     = 0;
        n_directed = 0;
        n_checked  = 0;
        n_mismatch = 0;
        bands_seen = '0;
        bins_seen  = '0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_extremes();
        test_band_limits();
        test_odd_interlace();
        test_pump_thresholds();
        // Let the pipeline empty completely before the random part.
        drain_results();
        test_random_traffic(400);
        test_back_to_back(100);

        drain_results();
        // Keep watching for stray strobes before the summary.
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Covered %0d timing items (%0d directed), %0d results checked",
                 n_sent, n_directed, n_checked);
        $display("%0d mismatches; VCO bands seen %b, pump bins seen %b",
                 n_mismatch, bands_seen, bins_seen);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/vapll_pkg.sv
hdl/video_adc_pll_setting_calc.sv
tb/sv/tb_video_adc_pll_setting_calc.sv
